// File: sv/sbe_pkg.sv
// shared types, constants and helper functions for the signal boundary extender
package sbe_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int INDEX_WIDTH = 16;
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int CFG_W       = (CNT_W > MODE_W) ? CNT_W : MODE_W;
    // folded position: wide enough for 2n - i and 2 - i
    localparam int POS_W       = ((INDEX_WIDTH > CNT_W + 1) ? INDEX_WIDTH : CNT_W + 1) + 2;
    // offset accumulator: one fold step per index unit, each step below 2^33
    localparam int ACC_W       = INDEX_WIDTH + DATA_W + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_LOWER_MODE   = 2'd1,
        CFG_UPPER_MODE   = 2'd2
    } t_cfg_index;

    typedef enum logic [MODE_W-1:0] {
        MODE_ZERO   = 3'd0,
        MODE_CONST  = 3'd1,
        MODE_CYCLIC = 3'd2,
        MODE_ODD    = 3'd3,
        MODE_EVEN   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_BAD_MODE  = 2'd2
    } t_status;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_FIRST,
        S_RD_LAST,
        S_FOLD,
        S_RD_ENTRY,
        S_DONE
    } t_state;

    // unknown mode codes behave as zero mode
    function automatic t_mode eff_mode(input logic [MODE_W-1:0] m);
        t_mode r;
        case (m)
            MODE_CONST:  r = MODE_CONST;
            MODE_CYCLIC: r = MODE_CYCLIC;
            MODE_ODD:    r = MODE_ODD;
            MODE_EVEN:   r = MODE_EVEN;
            default:     r = MODE_ZERO;
        endcase
        return r;
    endfunction

    // sample count clamped to 2..MAX_SAMPLES
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c < CNT_W'(2)) r = CNT_W'(2);
        if (c > CNT_W'(MAX_SAMPLES)) r = CNT_W'(MAX_SAMPLES);
        return r;
    endfunction

    // clamp accumulator to signed 32-bit range
    function automatic logic [DATA_W-1:0] sat_q16(input logic [ACC_W-1:0] v);
        logic in_range;
        in_range = (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[ACC_W-1]}});
        if (in_range) return v[DATA_W-1:0];
        else if (v[ACC_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
        else return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// File: sv/sbe_req_if.sv
// request channel: sample write or extended index query
interface sbe_req_if import sbe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [INDEX_WIDTH-1:0] sample_index;
    logic signed [DATA_W-1:0]      x_in;
    logic signed [DATA_W-1:0]      y_in;

    modport source (output valid, output opcode, output sample_index, output x_in,
                    output y_in, input ready);
    modport sink   (input valid, input opcode, input sample_index, input x_in,
                    input y_in, output ready);
endinterface

// File: sv/sbe_rsp_if.sv
// response channel: extended pair and status
interface sbe_rsp_if import sbe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
    logic [1:0]               status;

    modport source (output valid, output x_out, output y_out, output status, input ready);
    modport sink   (input valid, input x_out, input y_out, input status, output ready);
endinterface

// File: sv/signal_boundary_extender.sv
// signal boundary extender: sample table in one memory, sequential index folding
// write or mode error: request goes through S_DECODE to S_DONE; a query reads first and last
//   entries, folds the index in S_FOLD (one fold step a cycle), then reads the folded entry
// one request in flight: the next request is taken only after the response is loaded
// three registered table reads (first, last, folded entry) per query
// reset: synchronous, clears control and config (count 2, modes zero); table not cleared
module signal_boundary_extender import sbe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    sbe_req_if.sink              i_req,
    sbe_rsp_if.source            o_rsp
);

    // configuration registers
    logic [CNT_W-1:0]  r_sample_count;
    logic [MODE_W-1:0] r_lower_mode;
    logic [MODE_W-1:0] r_upper_mode;

    // control
    t_state r_state, n_state;
    logic   in_acc;
    logic   load_out;

    // request and work registers
    t_opcode                  r_op;
    logic signed [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0]        r_x_in, r_y_in;
    logic [DATA_W-1:0]        r_x1, r_y1, r_xn, r_yn;
    logic [DATA_W:0]          r_span;
    logic [ACC_W-1:0]         r_cx, r_cy;
    logic                     r_sx_neg, r_sy_neg, r_ydone;
    logic [DATA_W-1:0]        r_res_x, r_res_y;
    t_status                  r_res_status;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_x, r_out_y;
    t_status           r_out_status;

    // sample memory, x in the upper half
    logic [2*DATA_W-1:0] r_mem [MAX_SAMPLES];
    logic [2*DATA_W-1:0] r_rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;

    // derived config
    logic [CNT_W-1:0]        eff_cnt;
    t_mode                   lo_mode, up_mode;
    logic signed [POS_W-1:0] count_pos, cnt_m1;
    logic                    mixed_cyclic;

    // fold step
    logic                    pos_low, pos_high, in_range;
    t_mode                   mode;
    logic                    cyc;
    logic [DATA_W-1:0]       ex, ey, rd_x, rd_y;
    logic [ACC_W-1:0]        ex_ext, ey_ext, span_ext, mag_x, mag_y, rd_x_ext, rd_y_ext;
    logic                    neg_x;
    logic signed [POS_W-1:0] n_pos;
    logic [ACC_W-1:0]        n_cx, n_cy, fin_x, fin_y;
    logic                    n_sx_neg, n_sy_neg, n_ydone;
    t_status                 dec_status;

    assign eff_cnt      = eff_count(r_sample_count);
    assign lo_mode      = eff_mode(r_lower_mode);
    assign up_mode      = eff_mode(r_upper_mode);
    assign count_pos    = $signed(POS_W'(eff_cnt));
    assign cnt_m1       = count_pos - POS_W'(1);
    assign mixed_cyclic = (lo_mode == MODE_CYCLIC) != (up_mode == MODE_CYCLIC);

    // position against the table bounds
    assign pos_low  = r_pos < POS_W'(1);
    assign pos_high = r_pos > count_pos;
    assign in_range = !pos_low && !pos_high;

    assign rd_x     = r_rd_data[2*DATA_W-1:DATA_W];
    assign rd_y     = r_rd_data[DATA_W-1:0];
    assign rd_x_ext = {{(ACC_W-DATA_W){rd_x[DATA_W-1]}}, rd_x};
    assign rd_y_ext = {{(ACC_W-DATA_W){rd_y[DATA_W-1]}}, rd_y};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CNT_W'(2);
            r_lower_mode   <= MODE_ZERO;
            r_upper_mode   <= MODE_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_W-1:0];
                CFG_LOWER_MODE:   r_lower_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_UPPER_MODE:   r_upper_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, handshake and memory control
    always_comb begin
        n_state   = r_state;
        in_acc    = 1'b0;
        load_out  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(r_pos - POS_W'(1));
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                in_acc = i_req.valid;
                if (i_req.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_op == OP_WRITE) begin
                    mem_we  = in_range;
                    n_state = S_DONE;
                end else if (mixed_cyclic) begin
                    n_state = S_DONE;
                end else begin
                    mem_raddr = '0;
                    n_state   = S_RD_FIRST;
                end
            end
            S_RD_FIRST: begin
                mem_raddr = ADDR_W'(eff_cnt - CNT_W'(1));
                n_state   = S_RD_LAST;
            end
            S_RD_LAST: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (in_range) begin
                    mem_raddr = ADDR_W'(r_pos - POS_W'(1));
                    n_state   = S_RD_ENTRY;
                end
            end
            S_RD_ENTRY: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                load_out = !r_out_valid || o_rsp.ready;
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    // one fold step: cyclic wrap or point reflection about the near end
    always_comb begin
        mode     = pos_low ? lo_mode : up_mode;
        cyc      = (mode == MODE_CYCLIC);
        ex       = pos_low ? r_x1 : r_xn;
        ey       = pos_low ? r_y1 : r_yn;
        ex_ext   = {{(ACC_W-DATA_W){ex[DATA_W-1]}}, ex};
        ey_ext   = {{(ACC_W-DATA_W){ey[DATA_W-1]}}, ey};
        span_ext = {{(ACC_W-DATA_W-1){r_span[DATA_W]}}, r_span};

        mag_x = cyc ? span_ext : (ex_ext << 1);
        neg_x = cyc ? (pos_low ^ r_sx_neg) : r_sx_neg;
        n_cx  = r_cx + (neg_x ? ~mag_x : mag_x) + ACC_W'(neg_x);
        n_sx_neg = cyc ? r_sx_neg : !r_sx_neg;

        if (cyc) begin
            n_pos = pos_low ? r_pos + cnt_m1 : r_pos - cnt_m1;
        end else begin
            n_pos = pos_low ? POS_W'(2) - r_pos : (count_pos <<< 1) - r_pos;
        end

        mag_y    = (mode == MODE_ODD) ? (ey_ext << 1) : ey_ext;
        n_cy     = r_cy;
        n_sy_neg = r_sy_neg;
        n_ydone  = r_ydone;
        if (!cyc && !r_ydone) begin
            case (mode)
                MODE_ZERO: begin
                    n_ydone = 1'b1;
                end
                MODE_CONST: begin
                    n_cy    = r_cy + (r_sy_neg ? ~mag_y : mag_y) + ACC_W'(r_sy_neg);
                    n_ydone = 1'b1;
                end
                MODE_ODD: begin
                    n_cy     = r_cy + (r_sy_neg ? ~mag_y : mag_y) + ACC_W'(r_sy_neg);
                    n_sy_neg = !r_sy_neg;
                end
                default: ;
            endcase
        end

        // final value at the folded index
        fin_x = r_cx + (r_sx_neg ? ~rd_x_ext : rd_x_ext) + ACC_W'(r_sx_neg);
        fin_y = r_ydone ? r_cy
                        : r_cy + (r_sy_neg ? ~rd_y_ext : rd_y_ext) + ACC_W'(r_sy_neg);

        if (r_op == OP_WRITE) dec_status = in_range ? ST_OK : ST_BAD_INDEX;
        else dec_status = ST_BAD_MODE;
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= t_opcode'(i_req.opcode);
            r_pos  <= POS_W'(i_req.sample_index);
            r_x_in <= i_req.x_in;
            r_y_in <= i_req.y_in;
        end
        case (r_state)
            S_DECODE: begin
                r_cx         <= '0;
                r_cy         <= '0;
                r_sx_neg     <= 1'b0;
                r_sy_neg     <= 1'b0;
                r_ydone      <= 1'b0;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_status <= dec_status;
            end
            S_RD_FIRST: begin
                r_x1 <= rd_x;
                r_y1 <= rd_y;
            end
            S_RD_LAST: begin
                r_xn   <= rd_x;
                r_yn   <= rd_y;
                r_span <= {rd_x[DATA_W-1], rd_x} - {r_x1[DATA_W-1], r_x1};
            end
            S_FOLD: begin
                if (!in_range) begin
                    r_pos    <= n_pos;
                    r_cx     <= n_cx;
                    r_cy     <= n_cy;
                    r_sx_neg <= n_sx_neg;
                    r_sy_neg <= n_sy_neg;
                    r_ydone  <= n_ydone;
                end
            end
            S_RD_ENTRY: begin
                r_res_x      <= sat_q16(fin_x);
                r_res_y      <= sat_q16(fin_y);
                r_res_status <= ST_OK;
            end
            default: ;
        endcase
    end

    // sample memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= {r_x_in, r_y_in};
        r_rd_data <= r_mem[mem_raddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x      <= r_res_x;
            r_out_y      <= r_res_y;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.x_out  = r_out_x;
    assign o_rsp.y_out  = r_out_y;
    assign o_rsp.status = r_out_status;

endmodule

// File: sv/sbe_checker.sv
// port-level checks for the signal boundary extender, bound to the top level
module sbe_checker import sbe_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_x_out,
    input logic [DATA_W-1:0] i_y_out,
    input logic [1:0]        i_status
);

    // a waiting response holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_x_out)
            && $stable(i_y_out) && $stable(i_status))
        else $error("response changed while stalled");

    // error responses carry a zero pair
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_BAD_INDEX || i_status == ST_BAD_MODE)
            |-> i_x_out == '0 && i_y_out == '0)
        else $error("error response with nonzero pair");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // one request in flight: no request taken right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in work");

endmodule

bind signal_boundary_extender sbe_checker u_sbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_x_out     (o_rsp.x_out),
    .i_y_out     (o_rsp.y_out),
    .i_status    (o_rsp.status)
);

// File: sim/testbench.sv
// self-checking testbench for the signal boundary extender: directed table, then random phases
module testbench;
    import sbe_pkg::*;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_PERCENT    = 19;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        t_status                  status;
    } ext_result_t;

    typedef struct {
        int          cnt;
        int          lo;
        int          up;
        t_opcode     op;
        int          idx;
        logic [31:0] xv;
        logic [31:0] yv;
        bit          typed;
        logic [31:0] ex;
        logic [31:0] ey;
        t_status     est;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sbe_req_if req_ch ();
    sbe_rsp_if rsp_ch ();

    signal_boundary_extender uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // predictor state: sample table copy and register settings
    logic signed [DATA_W-1:0] x_samples [MAX_SAMPLES];
    logic signed [DATA_W-1:0] y_samples [MAX_SAMPLES];
    bit                       sample_written [MAX_SAMPLES];
    logic [CNT_W-1:0]         count_setting = CNT_W'(2);
    logic [MODE_W-1:0]        lower_setting = '0;
    logic [MODE_W-1:0]        upper_setting = '0;

    ext_result_t pending_extensions [$];
    stim_row_t   plan [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;
    int          hold_asked  = 0;
    int          hold_served = 0;

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("signal_boundary_extender test failed");
            $finish;
        end
    end

    // table size in force, clamped to 2..MAX_SAMPLES
    function automatic int active_count();
        if (count_setting < 2) return 2;
        if (count_setting > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(count_setting);
    endfunction

    // codes above even fall back to zero extension
    function automatic t_mode mode_code(input logic [MODE_W-1:0] raw);
        return (raw > MODE_W'(MODE_EVEN)) ? MODE_ZERO : t_mode'(raw);
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > (longint'(1) <<< 62)) return longint'(1) <<< 62;
        if (v < -(longint'(1) <<< 62)) return -(longint'(1) <<< 62);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] to_q16(input longint v);
        if (v > longint'(32'sh7fff_ffff)) return 32'h7fff_ffff;
        if (v < -longint'(64'sh8000_0000)) return 32'h8000_0000;
        return v[DATA_W-1:0];
    endfunction

    // expected response of one request; writes update the table copy
    function automatic ext_result_t extend_sample(input t_opcode op,
                                                  input logic signed [INDEX_WIDTH-1:0] idx,
                                                  input logic signed [DATA_W-1:0] xv,
                                                  input logic signed [DATA_W-1:0] yv);
        ext_result_t r;
        longint      n, i, x1, xn, y1, yn, span, ex, ey, sx, cx, sy, cy;
        bit          y_fixed, low;
        t_mode       lo_m, up_m, m;
        r       = '0;
        r.status = ST_OK;
        n       = active_count();
        i       = longint'(idx);
        lo_m    = mode_code(lower_setting);
        up_m    = mode_code(upper_setting);
        if (op == OP_WRITE) begin
            if (i < 1 || i > n) begin
                r.status = ST_BAD_INDEX;
            end else begin
                x_samples[i-1]      = xv;
                y_samples[i-1]      = yv;
                sample_written[i-1] = 1'b1;
            end
            return r;
        end
        if ((lo_m == MODE_CYCLIC) != (up_m == MODE_CYCLIC)) begin
            r.status = ST_BAD_MODE;
            return r;
        end
        x1 = longint'(x_samples[0]);
        xn = longint'(x_samples[n-1]);
        y1 = longint'(y_samples[0]);
        yn = longint'(y_samples[n-1]);
        span = xn - x1;
        sx = 1; cx = 0; sy = 1; cy = 0;
        y_fixed = 1'b0;
        // fold one step at a time until the index lies in the table
        while (i < 1 || i > n) begin
            low = (i < 1);
            m   = low ? lo_m : up_m;
            ex  = low ? x1 : xn;
            ey  = low ? y1 : yn;
            if (m == MODE_CYCLIC) begin
                cx = clamp_acc(cx + sx * (low ? -span : span));
                i  = low ? i + n - 1 : i - n + 1;
            end else begin
                cx = clamp_acc(cx + sx * 2 * ex);
                sx = -sx;
                if (!y_fixed) begin
                    case (m)
                        MODE_ZERO: y_fixed = 1'b1;
                        MODE_CONST: begin
                            cy      = clamp_acc(cy + sy * ey);
                            y_fixed = 1'b1;
                        end
                        MODE_ODD: begin
                            cy = clamp_acc(cy + sy * 2 * ey);
                            sy = -sy;
                        end
                        default: ;  // even: plain mirror, nothing to add
                    endcase
                end
                i = low ? 2 - i : 2 * n - i;
            end
        end
        r.x = to_q16(clamp_acc(cx + sx * longint'(x_samples[i-1])));
        r.y = to_q16(y_fixed ? cy : clamp_acc(cy + sy * longint'(y_samples[i-1])));
        return r;
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    // response check, sampled on the falling edge ahead of the transfer edge
    always @(negedge i_clk) begin
        ext_result_t want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_extensions.size() == 0) begin
                flag_mismatch("unexpected response x", 32'h0, rsp_ch.x_out);
            end else begin
                want = pending_extensions.pop_front();
                if (rsp_ch.x_out !== want.x) flag_mismatch("x_out", want.x, rsp_ch.x_out);
                if (rsp_ch.y_out !== want.y) flag_mismatch("y_out", want.y, rsp_ch.y_out);
                if (rsp_ch.status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
            end
        end
    end

    // response side: random stalls, one long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_asked != hold_served) begin
                hold_served  = hold_asked;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic logic [31:0] sample_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(1) == 1) v = {{8{v[23]}}, v[23:0]};
        return v;
    endfunction

    task automatic plan_row(input int cnt, input int lo, input int up, input t_opcode op,
                            input int idx, input logic [31:0] xv, input logic [31:0] yv,
                            input bit typed, input logic [31:0] ex, input logic [31:0] ey,
                            input t_status est);
        stim_row_t row;
        row = '{cnt, lo, up, op, idx, xv, yv, typed, ex, ey, est};
        plan.push_back(row);
    endtask

    // offer one request, record its expected response once taken
    task automatic push_request(input t_opcode op, input int idx, input logic [31:0] xv,
                                input logic [31:0] yv, input bit use_typed,
                                input ext_result_t typed);
        ext_result_t want;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.sample_index <= INDEX_WIDTH'(idx);
        req_ch.x_in         <= xv;
        req_ch.y_in         <= yv;
        @(negedge i_clk);
        while (req_ch.ready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        want = extend_sample(op, INDEX_WIDTH'(idx), xv, yv);
        if (use_typed) want = typed;
        pending_extensions.push_back(want);
    endtask

    // stop offering and wait for every outstanding response
    task automatic settle(input int tail);
        req_ch.valid <= 1'b0;
        while (pending_extensions.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int cnt, input int lo, input int up);
        settle(4);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_COUNT;
        cfg_data  <= CFG_W'(cnt);
        @(posedge i_clk);
        cfg_index <= CFG_LOWER_MODE;
        cfg_data  <= CFG_W'(lo);
        @(posedge i_clk);
        cfg_index <= CFG_UPPER_MODE;
        cfg_data  <= CFG_W'(up);
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        count_setting = CNT_W'(cnt);
        lower_setting = MODE_W'(lo);
        upper_setting = MODE_W'(up);
    endtask

    initial begin
        ext_result_t typed;
        int          n, cnt, lo, up, qi, wi;
        t_mode       lo_m;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SAMPLE_COUNT;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_WRITE;
        req_ch.sample_index = '0;
        req_ch.x_in         = '0;
        req_ch.y_in         = '0;
        foreach (sample_written[k]) sample_written[k] = 1'b0;

        // directed rows: cnt, lower, upper, op, index, x, y, typed, x, y, status
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, 0, 32'h1234_5678, 32'h9abc_def0,
                 1, 0, 0, ST_BAD_INDEX);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, 3, 32'h0001_0000, 32'h0002_0000,
                 1, 0, 0, ST_BAD_INDEX);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, -32768, 32'hffff_ffff, 32'h0,
                 1, 0, 0, ST_BAD_INDEX);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, 32767, 32'h0, 32'hffff_ffff,
                 1, 0, 0, ST_BAD_INDEX);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, 1, 32'h8000_0000, 32'h7fff_ffff,
                 1, 0, 0, ST_OK);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_WRITE, 2, 32'h7fff_ffff, 32'h8000_0000,
                 1, 0, 0, ST_OK);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_QUERY, 1, 0, 0,
                 1, 32'h8000_0000, 32'h7fff_ffff, ST_OK);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_QUERY, 2, 0, 0,
                 1, 32'h7fff_ffff, 32'h8000_0000, ST_OK);
        // folded queries, both output saturations, far index
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_QUERY, 0, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_QUERY, 3, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_ZERO, MODE_ZERO, OP_QUERY, -32768, 0, 0, 0, 0, 0, ST_OK);
        // count below two acts as two
        plan_row(0, MODE_CONST, MODE_CONST, OP_QUERY, 0, 0, 0, 0, 0, 0, ST_OK);
        plan_row(1, MODE_CONST, MODE_CONST, OP_QUERY, 5, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_CYCLIC, MODE_CYCLIC, OP_QUERY, -5, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_CYCLIC, MODE_CYCLIC, OP_QUERY, 32767, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_ODD, MODE_ODD, OP_QUERY, -3, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_ODD, MODE_ODD, OP_QUERY, 6, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_EVEN, MODE_EVEN, OP_QUERY, -2, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, MODE_EVEN, MODE_EVEN, OP_QUERY, 5, 0, 0, 0, 0, 0, ST_OK);
        // one side cyclic, even for an index inside the table
        plan_row(2, MODE_CYCLIC, MODE_ZERO, OP_QUERY, 5, 0, 0, 1, 0, 0, ST_BAD_MODE);
        plan_row(2, MODE_ODD, MODE_CYCLIC, OP_QUERY, 1, 0, 0, 1, 0, 0, ST_BAD_MODE);
        // unknown mode codes act as zero
        plan_row(2, 5, 7, OP_QUERY, 0, 0, 0, 0, 0, 0, ST_OK);
        plan_row(2, 6, 5, OP_QUERY, 4, 0, 0, 0, 0, 0, ST_OK);
        // count above the table size acts as the table size
        plan_row(2047, MODE_ZERO, MODE_ZERO, OP_WRITE, 1024, 32'h0003_8000, 32'hfffc_8000,
                 1, 0, 0, ST_OK);
        plan_row(2047, MODE_ZERO, MODE_ZERO, OP_QUERY, 1024, 0, 0,
                 1, 32'h0003_8000, 32'hfffc_8000, ST_OK);
        plan_row(2047, MODE_ZERO, MODE_ZERO, OP_WRITE, 1025, 32'h0, 32'h0,
                 1, 0, 0, ST_BAD_INDEX);
        plan_row(2047, MODE_CYCLIC, MODE_CYCLIC, OP_QUERY, 1025, 0, 0, 0, 0, 0, ST_OK);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (CNT_W'(plan[k].cnt) != count_setting || MODE_W'(plan[k].lo) != lower_setting
                    || MODE_W'(plan[k].up) != upper_setting)
                apply_setting(plan[k].cnt, plan[k].lo, plan[k].up);
            typed        = '0;
            typed.x      = plan[k].ex;
            typed.y      = plan[k].ey;
            typed.status = plan[k].est;
            push_request(plan[k].op, plan[k].idx, plan[k].xv, plan[k].yv, plan[k].typed, typed);
        end

        // random phases, each under its own register setting on a small table
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 1) begin
                cnt = 2;
            end else if ($urandom_range(9) == 0) begin
                cnt = $urandom_range(1);
            end else begin
                cnt = $urandom_range(48, 2);
            end
            lo   = $urandom_range(7);
            lo_m = mode_code(MODE_W'(lo));
            if ($urandom_range(99) < 30) up = $urandom_range(7);
            else if (lo_m == MODE_CYCLIC) up = MODE_CYCLIC;
            else begin
                up = $urandom_range(6);
                if (up >= int'(MODE_CYCLIC)) up++;
            end
            apply_setting(cnt, lo, up);
            n      = active_count();
            steady = (ph == 3);
            if (ph == 2) hold_asked++;

            // fill every entry in range before any query reads it
            for (int e = 1; e <= n; e++)
                if (!sample_written[e-1])
                    push_request(OP_WRITE, e, sample_value(), sample_value(), 0, '0);

            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 60) begin
                    if ($urandom_range(99) < 3) qi = int'($signed(16'($urandom)));
                    else qi = int'($urandom_range(7 * n + 4)) - (3 * n + 1);
                    push_request(OP_QUERY, qi, $urandom, $urandom, 0, '0);
                end else begin
                    case ($urandom_range(19))
                        0:       wi = int'($signed(16'($urandom)));
                        1:       wi = 0;
                        2:       wi = n + 1;
                        default: wi = $urandom_range(n, 1);
                    endcase
                    push_request(OP_WRITE, wi, sample_value(), sample_value(), 0, '0);
                end
            end
        end

        settle(16);
        if (mismatches == 0 && pending_extensions.size() == 0) begin
            $display("signal_boundary_extender test passed");
        end else begin
            $display("signal_boundary_extender test failed");
        end
        $finish;
    end

endmodule
